// ===== rtl/bch_pkg.sv =====
// ---------------------------------------------------------------------------
// BCH package
// Shared widths, codes, control structs and a helper function.
// ---------------------------------------------------------------------------
`default_nettype none

package bch_pkg;

  localparam int unsigned IO_W  = 32;
  localparam int unsigned OP_W  = 2;
  localparam int unsigned GEN_W = 16;
  localparam int unsigned MB_W  = 4;
  localparam int unsigned DEG_W = 4;

  localparam logic [GEN_W-1:0] GEN_RESET = 16'd1335;
  localparam logic [MB_W-1:0]  MB_RESET  = 4'd5;

  // register index within the configuration space
  localparam logic REG_GEN = 1'b0;
  localparam logic REG_MSG = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_REM  = 2'd0,
    OP_ENC  = 2'd1,
    OP_DEC  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // control word broadcast to every remainder cell
  typedef struct packed {
    logic clear;
    logic shift;
    logic in_bit;
  } lfsr_ctl_t;

  // candidate handed to the distance search
  typedef struct packed {
    logic valid;
    logic first;
  } cand_ctl_t;

  // position of the highest set bit, 0 for a zero polynomial
  function automatic logic [DEG_W-1:0] poly_degree(input logic [GEN_W-1:0] g);
    logic [DEG_W-1:0] d;
    d = '0;
    for (int i = 0; i < GEN_W; i++) begin
      if (g[i]) begin
        d = DEG_W'(i);
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bch_ifs.sv =====
// ---------------------------------------------------------------------------
// BCH channel interfaces
// Valid/ready channels for request beats and result beats.
// ---------------------------------------------------------------------------
`default_nettype none

interface bch_in_if;
  logic                       valid;
  logic                       ready;
  logic [bch_pkg::OP_W-1:0]   op;
  logic [bch_pkg::IO_W-1:0]   word_in;

  modport source (output valid, output op, output word_in, input ready);
  modport sink   (input valid, input op, input word_in, output ready);
endinterface

interface bch_out_if;
  logic                       valid;
  logic                       ready;
  logic [bch_pkg::IO_W-1:0]   word_out;
  logic                       ambiguous;

  modport source (output valid, output word_out, output ambiguous, input ready);
  modport sink   (input valid, input word_out, input ambiguous, output ready);
endinterface

`default_nettype wire

// ===== rtl/bch_encode_check_decode.sv =====
// ---------------------------------------------------------------------------
// BCH encode, check and decode
// Remainder, systematic encode and nearest-codeword decode over GF(2).
// ---------------------------------------------------------------------------
// Usage:
//   in_if carries one request beat (op, word_in); out_if returns exactly one
//   result beat (word_out, ambiguous) per request, in order. The APB port
//   holds generator_poly at 0x0 and message_bits at 0x4; write them only
//   while no request is in flight.
// Throughput (one request at a time, taken in IDLE):
//   remainder / encode : one bit per cycle through the division chain of
//                        16 cells.
//   decode             : the chain first builds m basis codewords, then the
//                        scan counter offers 2^m candidates, one per cycle,
//                        followed by drain and result;
//                        m = min(message_bits, MAX_MESSAGE_BITS).
//   unused op          : result zero.
// Reset: registers return to 1335 and 5, the sequencer goes idle and the
//   result register empties. No clearing pass is needed.
// Stall: a finished result waits in the output register; a new request is
//   still taken, and its own result holds in the final state until the
//   output register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module bch_encode_check_decode #(
  parameter int unsigned WORD_BITS        = 32,
  parameter int unsigned MAX_MESSAGE_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  bch_in_if.sink           in_if,
  bch_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import bch_pkg::*;

  localparam int unsigned MMB    = MAX_MESSAGE_BITS;
  localparam int unsigned MBC_W  = $clog2(MMB + 1);
  localparam int unsigned BIDX_W = (MMB > 1) ? $clog2(MMB) : 1;
  localparam int unsigned NW     = $clog2(WORD_BITS + GEN_W + MMB + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_BASIS = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  // configuration registers
  logic [GEN_W-1:0] gen_q;
  logic [MB_W-1:0]  mb_q;
  logic             cfg_wr;

  // sequencer
  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [WORD_BITS-1:0] sreg_q, sreg_d;
  logic [NW-1:0]        n_q, n_d;
  logic [MMB-1:0]       k_q, k_d;
  logic [WORD_BITS-1:0] cw_q, cw_d;
  logic [WORD_BITS-1:0] basis_q [MMB];

  // output register
  logic                 out_valid_q;
  logic [IO_W-1:0]      out_word_q;
  logic                 out_amb_q;

  logic                 accept;
  logic                 fin_write;
  logic [DEG_W-1:0]     gdeg;
  logic                 gzero;
  logic [MBC_W-1:0]     mbc;
  logic [MMB-1:0]       last_k;
  logic [MMB-1:0]       k_nx;
  logic [BIDX_W-1:0]    flip_idx;
  logic [WORD_BITS-1:0] word_ext;
  logic [WORD_BITS-1:0] rem_ext;
  logic [WORD_BITS-1:0] rem_sel;
  logic [NW-1:0]        basis_end;
  logic [NW-1:0]        pow;
  logic [NW-1:0]        cap_full;
  logic                 cap_en;
  logic [WORD_BITS-1:0] cap_val;
  logic [IO_W-1:0]      res_word;
  logic                 res_amb;

  lfsr_ctl_t            lfsr_ctl;
  logic [GEN_W-1:0]     rem;
  cand_ctl_t            cand;
  logic                 srch_busy;
  logic [MMB-1:0]       best_msg;
  logic                 srch_tie;

  // -------------------------------------------------------------------------
  // APB register file
  // -------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MSG) ? 32'(mb_q) : 32'(gen_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= GEN_RESET;
      mb_q  <= MB_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_GEN: gen_q <= pwdata[GEN_W-1:0];
        REG_MSG: mb_q  <= pwdata[MB_W-1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Derived configuration
  // -------------------------------------------------------------------------
  assign gdeg  = poly_degree(gen_q);
  assign gzero = (gen_q == '0);
  // clamp the tried width to what the scan counter can hold
  assign mbc   = (32'(mb_q) > MMB) ? MBC_W'(MMB) : MBC_W'(mb_q);
  assign last_k = ~({MMB{1'b1}} << mbc);

  assign accept   = in_if.valid && in_if.ready;
  assign word_ext = WORD_BITS'(in_if.word_in);
  assign rem_ext  = WORD_BITS'(rem);
  // a zero generator never reduces: the remainder is the word itself
  assign rem_sel  = gzero ? word_q : rem_ext;

  // basis phase: at count n the chain holds x^(n-1) mod g
  assign basis_end = NW'(gdeg) + NW'(mbc);
  assign pow       = n_q - NW'(1);
  assign cap_full  = pow - NW'(gdeg);
  assign cap_en    = (state_q == S_BASIS) && (n_q > NW'(gdeg));
  assign cap_val   = (gzero || (32'(pow) >= WORD_BITS)) ? '0
                   : ((WORD_BITS'(1) << pow) | rem_ext);

  // Gray order: candidate k+1 differs from k in the lowest set bit of k+1
  assign k_nx = k_q + MMB'(1);
  always_comb begin
    flip_idx = '0;
    for (int i = MMB - 1; i >= 0; i--) begin
      if (k_nx[i]) begin
        flip_idx = BIDX_W'(i);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    word_d   = word_q;
    sreg_d   = sreg_q;
    n_d      = n_q;
    k_d      = k_q;
    cw_d     = cw_q;
    lfsr_ctl = '0;
    cand     = '0;
    fin_write = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = op_e'(in_if.op);
          n_d    = '0;
          k_d    = '0;
          cw_d   = '0;
          lfsr_ctl.clear = 1'b1;
          if (op_e'(in_if.op) == OP_ENC) begin
            word_d = word_ext << gdeg;
            sreg_d = word_ext << gdeg;
          end else begin
            word_d = word_ext;
            sreg_d = word_ext;
          end
          case (op_e'(in_if.op)) inside
            OP_REM, OP_ENC: state_d = S_DIV;
            OP_DEC:         state_d = S_BASIS;
            default:        state_d = S_FIN;
          endcase
        end
      end
      S_DIV: begin
        // feed the word MSB first through the division chain
        lfsr_ctl.shift  = 1'b1;
        lfsr_ctl.in_bit = sreg_q[WORD_BITS-1];
        sreg_d = sreg_q << 1;
        n_d    = n_q + NW'(1);
        if (n_q == NW'(WORD_BITS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_BASIS: begin
        // divide a single one followed by zeros to get x^n mod g
        lfsr_ctl.shift  = (n_q < basis_end);
        lfsr_ctl.in_bit = (n_q == '0);
        if (n_q == basis_end) begin
          state_d = S_SCAN;
        end else begin
          n_d = n_q + NW'(1);
        end
      end
      S_SCAN: begin
        cand.valid = 1'b1;
        cand.first = (k_q == '0);
        k_d  = k_nx;
        cw_d = cw_q ^ basis_q[flip_idx];
        if (k_q == last_k) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!srch_busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_if.ready) begin
          fin_write = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_word = '0;
    res_amb  = 1'b0;
    case (op_q)
      OP_REM: res_word = IO_W'(rem_sel);
      OP_ENC: res_word = IO_W'(word_q ^ rem_sel);
      OP_DEC: begin
        res_amb  = srch_tie;
        res_word = srch_tie ? '0 : IO_W'(best_msg);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      n_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      n_q     <= n_d;
      k_q     <= k_d;
      if (fin_write) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    sreg_q <= sreg_d;
    cw_q   <= cw_d;
    if (cap_en) begin
      basis_q[cap_full[BIDX_W-1:0]] <= cap_val;
    end
    if (fin_write) begin
      out_word_q <= res_word;
      out_amb_q  <= res_amb;
    end
  end

  // -------------------------------------------------------------------------
  // Datapath units
  // -------------------------------------------------------------------------
  bch_lfsr u_lfsr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lfsr_ctl),
    .gen_i  (gen_q),
    .gdeg_i (gdeg),
    .rem_o  (rem)
  );

  bch_search #(
    .WORD_BITS        (WORD_BITS),
    .MAX_MESSAGE_BITS (MMB)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cand_i     (cand),
    .word_i     (word_q),
    .cw_i       (cw_q),
    .msg_i      (k_q ^ (k_q >> 1)),
    .busy_o     (srch_busy),
    .best_msg_o (best_msg),
    .tie_o      (srch_tie)
  );

  assign in_if.ready      = (state_q == S_IDLE);
  assign out_if.valid     = out_valid_q;
  assign out_if.word_out  = out_word_q;
  assign out_if.ambiguous = out_amb_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("request beat taken but sequencer stayed idle");

  a_amb_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_amb_q) |-> (out_word_q == '0))
    else $error("ambiguous result carries a nonzero word");

  a_fin_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> !srch_busy)
    else $error("result formed while search pipeline still busy");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (32'(n_q) < WORD_BITS))
    else $error("division ran past the word width");

endmodule

`default_nettype wire

// ===== rtl/bch_cell.sv =====
// ---------------------------------------------------------------------------
// BCH remainder cell
// One bit of the division register: take the neighbor bit, fold in feedback.
// ---------------------------------------------------------------------------
`default_nettype none

module bch_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bch_pkg::lfsr_ctl_t ctl_i,
  input  wire logic               left_i,
  input  wire logic               fb_i,
  input  wire logic               gbit_i,
  output logic                    q_o
);
  import bch_pkg::*;

  logic bit_q;
  logic bit_d;

  always_comb begin
    bit_d = bit_q;
    if (ctl_i.clear) begin
      bit_d = 1'b0;
    end else if (ctl_i.shift) begin
      bit_d = left_i ^ (fb_i & gbit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign q_o = bit_q;

endmodule

`default_nettype wire

// ===== rtl/bch_lfsr.sv =====
// ---------------------------------------------------------------------------
// BCH division chain
// Row of remainder cells dividing a serial bit stream by the generator.
// ---------------------------------------------------------------------------
`default_nettype none

module bch_lfsr (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bch_pkg::lfsr_ctl_t            ctl_i,
  input  wire logic [bch_pkg::GEN_W-1:0]     gen_i,
  input  wire logic [bch_pkg::DEG_W-1:0]     gdeg_i,
  output logic      [bch_pkg::GEN_W-1:0]     rem_o
);
  import bch_pkg::*;

  logic [GEN_W-1:0] rem;
  logic [GEN_W-1:0] tap;
  logic             fb;

  // value each cell sees before reduction; the bit at the degree is the feedback
  assign tap = {rem[GEN_W-2:0], ctl_i.in_bit};
  assign fb  = tap[gdeg_i];

  for (genvar i = 0; i < GEN_W; i++) begin : g_cell
    bch_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_i),
      .left_i (tap[i]),
      .fb_i   (fb),
      .gbit_i (gen_i[i]),
      .q_o    (rem[i])
    );
  end

  assign rem_o = rem;

endmodule

`default_nettype wire

// ===== rtl/bch_search.sv =====
// ---------------------------------------------------------------------------
// BCH nearest-codeword search
// Two stages: Hamming distance of one candidate, then best and tie tracking.
// ---------------------------------------------------------------------------
`default_nettype none

module bch_search #(
  parameter int unsigned WORD_BITS        = 32,
  parameter int unsigned MAX_MESSAGE_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bch_pkg::cand_ctl_t            cand_i,
  input  wire logic [WORD_BITS-1:0]          word_i,
  input  wire logic [WORD_BITS-1:0]          cw_i,
  input  wire logic [MAX_MESSAGE_BITS-1:0]   msg_i,
  output logic                               busy_o,
  output logic [MAX_MESSAGE_BITS-1:0]        best_msg_o,
  output logic                               tie_o
);
  import bch_pkg::*;

  localparam int unsigned DW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0]        diff;
  logic [DW-1:0]               hdist;
  logic                        s1_valid_q;
  logic                        s1_first_q;
  logic [DW-1:0]               s1_dist_q;
  logic [MAX_MESSAGE_BITS-1:0] s1_msg_q;
  logic [DW-1:0]               best_dist_q;
  logic [MAX_MESSAGE_BITS-1:0] best_msg_q;
  logic                        tie_q;

  assign diff = word_i ^ cw_i;

  always_comb begin
    hdist = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      hdist = hdist + DW'(diff[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      tie_q      <= 1'b0;
    end else begin
      s1_valid_q <= cand_i.valid;
      if (s1_valid_q) begin
        if (s1_first_q || (s1_dist_q < best_dist_q)) begin
          tie_q <= 1'b0;
        end else if (s1_dist_q == best_dist_q) begin
          tie_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_i.valid) begin
      s1_first_q <= cand_i.first;
      s1_dist_q  <= hdist;
      s1_msg_q   <= msg_i;
    end
    if (s1_valid_q && (s1_first_q || (s1_dist_q < best_dist_q))) begin
      best_dist_q <= s1_dist_q;
      best_msg_q  <= s1_msg_q;
    end
  end

  assign busy_o     = s1_valid_q;
  assign best_msg_o = best_msg_q;
  assign tie_o      = tie_q;

endmodule

`default_nettype wire

// ===== tb/sv/bch_result_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// BCH result checker
// Watches request beats, result beats and register writes of the BCH block,
// predicts every result and compares it field by field, oldest first.
// ---------------------------------------------------------------------------
module bch_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  bch_in_if           in_mon,
  bch_out_if          out_mon,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  import bch_pkg::*;

  localparam int MAX_TRIED_BITS = 8;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [IO_W-1:0] word;
    logic            amb;
  } bch_result_t;

  bch_result_t      expected_q[$];
  logic [GEN_W-1:0] gen_poly_q;
  logic [MB_W-1:0]  msg_bits_q;

  // highest set bit of the generator, -1 when it is zero
  function automatic int poly_order(input logic [GEN_W-1:0] g);
    int d;
    d = -1;
    for (int i = 0; i < GEN_W; i++) begin
      if (g[i]) begin
        d = i;
      end
    end
    return d;
  endfunction

  function automatic logic [IO_W-1:0] mod_generator(input logic [IO_W-1:0] w);
    int d;
    logic [IO_W-1:0] r;
    d = poly_order(gen_poly_q);
    r = w;
    if (d >= 0) begin
      for (int p = IO_W - 1; p >= d; p--) begin
        if (r[p]) begin
          r = r ^ (IO_W'(gen_poly_q) << (p - d));
        end
      end
    end
    return r;
  endfunction

  function automatic logic [IO_W-1:0] systematic_codeword(input logic [IO_W-1:0] msg);
    int d;
    logic [IO_W-1:0] s;
    d = poly_order(gen_poly_q);
    if (d < 0) begin
      d = 0;
    end
    s = msg << d;
    return s ^ mod_generator(s);
  endfunction

  // try every message; a tie on the final best distance answers zero
  function automatic bch_result_t nearest_message(input logic [IO_W-1:0] w);
    int m;
    int hdist;
    int best_dist;
    logic [IO_W-1:0] best_msg;
    logic tie;
    bch_result_t r;
    m = (int'(msg_bits_q) > MAX_TRIED_BITS) ? MAX_TRIED_BITS : int'(msg_bits_q);
    best_dist = 0;
    best_msg  = '0;
    tie       = 1'b0;
    for (int v = 0; v < (1 << m); v++) begin
      hdist = $countones(w ^ systematic_codeword(IO_W'(v)));
      if (v == 0 || hdist < best_dist) begin
        best_msg  = IO_W'(v);
        best_dist = hdist;
        tie       = 1'b0;
      end else if (hdist == best_dist) begin
        tie = 1'b1;
      end
    end
    r.word = tie ? '0 : best_msg;
    r.amb  = tie;
    return r;
  endfunction

  function automatic bch_result_t predict_result(input op_e op, input logic [IO_W-1:0] w);
    bch_result_t r;
    r = '0;
    case (op)
      OP_REM: r.word = mod_generator(w);
      OP_ENC: r.word = systematic_codeword(w);
      OP_DEC: r = nearest_message(w);
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bch_result_t exp_r;
    if (!rst_ni) begin
      gen_poly_q   = GEN_RESET;
      msg_bits_q   = MB_RESET;
      fail_count_o = 0;
      pending_o    = 0;
      expected_q.delete();
    end else begin
      // register write completes on the access cycle
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_GEN) begin
          gen_poly_q = pwdata_i[GEN_W-1:0];
        end else begin
          msg_bits_q = pwdata_i[MB_W-1:0];
        end
      end
      // compare the result beat before queueing a new request beat
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          note_mismatch($sformatf("result with nothing expected: word_out %h ambiguous %b",
                                  out_mon.word_out, out_mon.ambiguous));
        end else begin
          exp_r = expected_q.pop_front();
          if (out_mon.word_out !== exp_r.word) begin
            note_mismatch($sformatf("word_out mismatch: expected %h, got %h",
                                    exp_r.word, out_mon.word_out));
          end
          if (out_mon.ambiguous !== exp_r.amb) begin
            note_mismatch($sformatf("ambiguous mismatch: expected %b, got %b",
                                    exp_r.amb, out_mon.ambiguous));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(predict_result(op_e'(in_mon.op), in_mon.word_in));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== tb/sv/bch_encode_check_decode_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// BCH encode, check and decode testbench
// Drives request beats and register writes into the block through several
// generator and message-width settings and idle patterns; a checker beside
// the block predicts and compares every result beat.
// ---------------------------------------------------------------------------
module bch_encode_check_decode_tb;
  import bch_pkg::*;

  // slowest correct run: every beat a full 8-bit decode plus stalls on
  // both sides; the limit is several times that
  localparam int CYCLE_LIMIT    = 3_000_000;
  localparam int NUM_PHASES     = 10;
  localparam int RAND_PER_PHASE = 175;
  localparam int DRAIN_CYCLES   = 300;
  localparam int MAX_TRIED_BITS = 8;

  localparam logic [2:0] GEN_ADDR = {REG_GEN, 2'b00};
  localparam logic [2:0] MSG_ADDR = {REG_MSG, 2'b00};

  localparam op_e ALL_OPS [4] = '{OP_REM, OP_ENC, OP_DEC, OP_NONE};

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int fail_count;
  int pending;
  int cycle_cnt;

  // what the stimulus believes is loaded, used to aim decode words
  logic [GEN_W-1:0] cur_gen;
  int               cur_msg_bits;

  bch_in_if  req_if ();
  bch_out_if rsp_if ();

  bch_encode_check_decode uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (req_if),
    .out_if  (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bch_result_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (req_if),
    .out_mon      (rsp_if),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: a hang anywhere ends the run as a failure
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL bch_encode_check_decode");
    $finish;
  end

  // result side: one ready decision per cycle, stall rate set by the phase
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // systematic codeword of a short message, used to land decode words near
  // real codewords so that both clean wins and ties show up
  function automatic logic [31:0] stim_codeword(input logic [GEN_W-1:0] g,
                                                input logic [7:0] msg);
    int d;
    logic [31:0] s;
    logic [31:0] r;
    d = 0;
    for (int i = 0; i < GEN_W; i++) begin
      if (g[i]) begin
        d = i;
      end
    end
    s = 32'(msg) << d;
    r = s;
    for (int p = 31; p >= d; p--) begin
      if (r[p]) begin
        r = r ^ (32'(g) << (p - d));
      end
    end
    return s ^ r;
  endfunction

  function automatic logic [31:0] pick_word(input op_e op);
    logic [31:0] w;
    logic [7:0]  msg;
    msg = 8'($urandom_range((1 << cur_msg_bits) - 1));
    w   = $urandom;
    // remainder and decode: mostly codewords with a few flipped bits
    if ((op == OP_DEC || op == OP_REM) && $urandom_range(99) < 60) begin
      w = stim_codeword(cur_gen, msg);
      repeat ($urandom_range(3)) w[$urandom_range(31)] ^= 1'b1;
    end
    // now and then cut the word short to hit low-degree words
    if ($urandom_range(3) == 0) begin
      w &= 32'hFFFF_FFFF >> $urandom_range(31);
    end
    return w;
  endfunction

  function automatic op_e pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 28) return OP_REM;
    if (r < 56) return OP_ENC;
    if (r < 95) return OP_DEC;
    return OP_NONE;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  // is taken, with valid still high so a following beat goes back to back
  task automatic send_beat(input op_e op, input logic [31:0] w);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.op      <= op;
    req_if.word_in <= w;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_beat();
    op_e op;
    op = pick_op();
    send_beat(op, pick_word(op));
  endtask

  // setup cycle and access cycle, then psel and penable drop before the next access
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // upper data bits carry noise; the block must ignore them
  task automatic load_config(input logic [GEN_W-1:0] g, input logic [MB_W-1:0] m);
    apb_write(GEN_ADDR, {16'($urandom), g});
    apb_write(MSG_ADDR, {28'($urandom), m});
    cur_gen      = g;
    cur_msg_bits = (int'(m) > MAX_TRIED_BITS) ? MAX_TRIED_BITS : int'(m);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [GEN_W-1:0] g;
    logic [MB_W-1:0]  m;
    logic [31:0]      cw;

    req_if.valid   = 1'b0;
    req_if.op      = OP_REM;
    req_if.word_in = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst_ni         = 1'b0;
    cur_gen        = GEN_RESET;
    cur_msg_bits   = int'(MB_RESET);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed beats at the reset setting (degree 10, five message bits)
    send_beat(OP_REM, 32'h0000_0000);
    send_beat(OP_REM, 32'hFFFF_FFFF);
    send_beat(OP_REM, 32'(GEN_RESET));         // generator itself: remainder zero
    send_beat(OP_REM, 32'h0000_03FF);          // below the generator degree
    send_beat(OP_REM, 32'h0000_0400);          // exactly at the generator degree
    send_beat(OP_REM, 32'h8000_0000);
    send_beat(OP_ENC, 32'h0000_0000);
    send_beat(OP_ENC, 32'hFFFF_FFFF);          // top bits shifted out
    send_beat(OP_ENC, 32'h0000_001F);
    send_beat(OP_ENC, 32'h003F_FFFF);          // just fits after the shift
    send_beat(OP_ENC, 32'h0040_0000);          // lone bit shifted out
    cw = stim_codeword(GEN_RESET, 8'h15);
    send_beat(OP_DEC, 32'h0000_0000);
    send_beat(OP_DEC, 32'hFFFF_FFFF);
    send_beat(OP_DEC, cw);                     // clean codeword
    send_beat(OP_DEC, cw ^ 32'h0000_0001);     // one bit off
    send_beat(OP_DEC, cw ^ 32'h8000_0000);     // flip outside the code span
    send_beat(OP_DEC, 32'hAAAA_AAAA);
    send_beat(OP_DEC, 32'h5555_5555);
    send_beat(OP_NONE, 32'h0000_0000);
    send_beat(OP_NONE, 32'hFFFF_FFFF);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // hold off register writes until every result of the last phase is in
      if (ph != 0) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        req_if.valid <= 1'b0;
        wait_drained();
        case (ph)
          1: begin g = 16'hFFFF; m = 4'd8;  end  // widest generator, widest search
          2: begin g = 16'h0002; m = 4'd1;  end  // degree one, single message bit
          3: begin g = 16'h0000; m = 4'd0;  end  // zero generator, only message zero
          4: begin g = 16'h0001; m = 4'hF;  end  // generator of one, width clamped
          5: begin g = 16'h8000; m = 4'd8;  end
          6: begin g = GEN_W'($urandom_range(65535, 2)); m = MB_W'($urandom_range(4, 1)); end
          7: begin g = 16'h0003; m = 4'd12; end
          8: begin g = GEN_W'($urandom_range(65535, 2)); m = 4'd9; end
          default: begin g = GEN_RESET; m = MB_RESET; end
        endcase
        load_config(g, m);
      end

      // rotate the idle pattern: none, sender, receiver, both
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
        default: begin src_idle_pct = 12; sink_stall_pct = 12; end
      endcase

      // all-zero and all-one words under every operation at this setting
      foreach (ALL_OPS[k]) begin
        send_beat(ALL_OPS[k], 32'h0000_0000);
        send_beat(ALL_OPS[k], 32'hFFFF_FFFF);
      end
      repeat (RAND_PER_PHASE) send_random_beat();
    end

    // drop valid, let every result through, then watch for stray beats
    req_if.valid <= 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS bch_encode_check_decode");
    end else begin
      $display("FAIL bch_encode_check_decode");
    end
    $finish;
  end

endmodule
